@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the pulse code transmitter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset
`define DPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked out of reset
`define DPCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define DPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dpct_pkg.sv @@
// Types, constants and code tables of the doorbell pulse code transmitter
package dpct_pkg;

  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned REPEAT_W = 7;
  localparam int unsigned GAP_W    = 6;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CH_W     = 5;
  localparam int unsigned SND_W    = 3;

  localparam logic [SLOT_W-1:0]   SLOT_RST   = 10'd200;
  localparam logic [REPEAT_W-1:0] REPEAT_RST = 7'd100;
  localparam logic [GAP_W-1:0]    GAP_RST    = 6'd30;

  // Last code bit index and trailer position
  localparam logic [3:0] LAST_BIT = 4'd11;
  localparam logic [3:0] TRAILER  = 4'd12;

  typedef enum logic [1:0] {
    CFG_SLOT_TICKS   = 2'd0,
    CFG_REPEAT_COUNT = 2'd1,
    CFG_GAP_SLOTS    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_BIT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0]  channel;
    logic [SND_W-1:0] sound;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } in_slot_t;

  function automatic logic [3:0] chan_code(input logic [3:0] idx);
    logic [3:0] c;
    case (idx)
      4'd0:    c = 4'hF;
      4'd1:    c = 4'h3;
      4'd2:    c = 4'hB;
      4'd3:    c = 4'h0;
      4'd4:    c = 4'h8;
      4'd5:    c = 4'h4;
      4'd6:    c = 4'hC;
      4'd7:    c = 4'h5;
      4'd8:    c = 4'hD;
      4'd9:    c = 4'h1;
      4'd10:   c = 4'h9;
      4'd11:   c = 4'h2;
      4'd12:   c = 4'hA;
      4'd13:   c = 4'h6;
      4'd14:   c = 4'hE;
      default: c = 4'h7;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sound_code(input logic [SND_W-1:0] snd);
    logic [7:0] c;
    case (snd)
      3'd1:    c = 8'hF7;
      3'd2:    c = 8'hFB;
      default: c = 8'hFD;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/dpct_in_stage.sv @@
// Input register stage of the pulse code transmitter
module dpct_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpct_pkg::item_t   in_item,
  input  logic              take,
  output dpct_pkg::in_slot_t slot
);

  logic            vld_r;
  logic            vld_nxt;
  dpct_pkg::item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign slot.vld  = vld_r;
  assign slot.item = item_r;

endmodule

@@ rtl/dpct_core.sv @@
// Frame sequencer, configuration registers and result register
`include "assert_macros.svh"

module dpct_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dpct_pkg::in_slot_t              slot,
  output logic                            take,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [dpct_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_line_level,
  output logic                            out_busy_res,
  output logic                            out_rejected,
  output logic                            out_finished
);

  // configuration
  logic [dpct_pkg::SLOT_W-1:0]   slot_ticks_r;
  logic [dpct_pkg::REPEAT_W-1:0] repeat_count_r;
  logic [dpct_pkg::GAP_W-1:0]    gap_slots_r;

  // sequencer state
  logic                            active_r, active_nxt;
  logic [3:0]                      chan_code_r, chan_code_nxt;
  logic [7:0]                      snd_code_r, snd_code_nxt;
  logic [3:0]                      bit_pos_r, bit_pos_nxt;
  dpct_pkg::phase_t                phase_r, phase_nxt;
  logic [dpct_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic [dpct_pkg::REPEAT_W-1:0]   frames_r, frames_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic level_r, busy_r, rej_r, fin_r;

  logic                          level, busy, rej, fin;
  logic                          start_ok, is_start, end_fr;
  logic [dpct_pkg::SLOT_W-1:0]   slen;
  logic [dpct_pkg::TICK_W-1:0]   gap_len;
  logic [dpct_pkg::TICK_W:0]     t_inc;
  logic [11:0]                   code_word;
  logic [3:0]                    code_idx;
  logic                          cur_lvl;
  logic                          in_gap;
  dpct_pkg::item_t               it;

  assign it        = slot.item;
  assign take      = slot.vld && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_ticks_r   <= dpct_pkg::SLOT_RST;
      repeat_count_r <= dpct_pkg::REPEAT_RST;
      gap_slots_r    <= dpct_pkg::GAP_RST;
    end else if (cfg_valid) begin
      case (dpct_pkg::cfg_idx_t'(cfg_index))
        dpct_pkg::CFG_SLOT_TICKS:   slot_ticks_r   <= cfg_wdata;
        dpct_pkg::CFG_REPEAT_COUNT: repeat_count_r <= cfg_wdata[dpct_pkg::REPEAT_W-1:0];
        dpct_pkg::CFG_GAP_SLOTS:    gap_slots_r    <= cfg_wdata[dpct_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign slen    = (slot_ticks_r == '0) ? dpct_pkg::SLOT_W'(1) : slot_ticks_r;
  assign gap_len = dpct_pkg::TICK_W'(gap_slots_r) * dpct_pkg::TICK_W'(slen);
  assign t_inc   = {1'b0, tick_r} + (dpct_pkg::TICK_W+1)'(1);

  // Level of the current position with the stored state
  assign code_word = {chan_code_r, snd_code_r};
  assign code_idx  = dpct_pkg::LAST_BIT - bit_pos_r;
  always_comb begin
    if (!active_r) begin
      cur_lvl = 1'b0;
    end else begin
      case (phase_r)
        dpct_pkg::PH_HIGH: cur_lvl = 1'b1;
        dpct_pkg::PH_LOW:  cur_lvl = 1'b0;
        default:           cur_lvl = (bit_pos_r >= dpct_pkg::TRAILER) ? 1'b0
                                                                     : code_word[code_idx];
      endcase
    end
  end

  assign is_start = it.req_type;
  assign start_ok = is_start && !active_r && (it.channel != '0) &&
                    (it.channel <= dpct_pkg::CH_W'(16)) &&
                    (it.sound != '0) && (it.sound <= dpct_pkg::SND_W'(3));
  assign in_gap   = (bit_pos_r >= dpct_pkg::TRAILER) && (phase_r != dpct_pkg::PH_HIGH);

  always_comb begin
    active_nxt    = active_r;
    chan_code_nxt = chan_code_r;
    snd_code_nxt  = snd_code_r;
    bit_pos_nxt   = bit_pos_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    frames_nxt    = frames_r;
    end_fr        = 1'b0;
    rej           = 1'b0;
    fin           = 1'b0;
    level         = cur_lvl;
    busy          = active_r;
    if (is_start) begin
      if (start_ok) begin
        chan_code_nxt = dpct_pkg::chan_code(4'(it.channel - dpct_pkg::CH_W'(1)));
        snd_code_nxt  = dpct_pkg::sound_code(it.sound);
        bit_pos_nxt   = '0;
        phase_nxt     = dpct_pkg::PH_HIGH;
        tick_nxt      = '0;
        frames_nxt    = (repeat_count_r == '0) ? dpct_pkg::REPEAT_W'(1) : repeat_count_r;
        active_nxt    = 1'b1;
        level         = 1'b1;
        busy          = 1'b1;
      end else begin
        rej = 1'b1;
      end
    end else if (active_r) begin
      if (in_gap) begin
        if (t_inc >= {1'b0, gap_len}) begin
          end_fr = 1'b1;
        end else begin
          tick_nxt = t_inc[dpct_pkg::TICK_W-1:0];
        end
      end else if (t_inc >= (dpct_pkg::TICK_W+1)'(slen)) begin
        tick_nxt = '0;
        if (bit_pos_r >= dpct_pkg::TRAILER) begin
          if (gap_slots_r == '0) begin
            end_fr = 1'b1;
          end else begin
            phase_nxt = dpct_pkg::PH_LOW;
          end
        end else if (phase_r == dpct_pkg::PH_BIT) begin
          phase_nxt   = dpct_pkg::PH_HIGH;
          bit_pos_nxt = bit_pos_r + 4'd1;
        end else begin
          phase_nxt = (phase_r == dpct_pkg::PH_HIGH) ? dpct_pkg::PH_LOW : dpct_pkg::PH_BIT;
        end
      end else begin
        tick_nxt = t_inc[dpct_pkg::TICK_W-1:0];
      end
      // wrap to the next frame, or stop after the last one
      if (end_fr) begin
        bit_pos_nxt = '0;
        phase_nxt   = dpct_pkg::PH_HIGH;
        tick_nxt    = '0;
        if (frames_r <= dpct_pkg::REPEAT_W'(1)) begin
          frames_nxt = '0;
          active_nxt = 1'b0;
          fin        = 1'b1;
        end else begin
          frames_nxt = frames_r - dpct_pkg::REPEAT_W'(1);
        end
      end
    end
  end

  assign out_valid_nxt = take ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      chan_code_r <= '0;
      snd_code_r  <= '0;
      bit_pos_r   <= '0;
      phase_r     <= dpct_pkg::PH_HIGH;
      tick_r      <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        active_r    <= active_nxt;
        chan_code_r <= chan_code_nxt;
        snd_code_r  <= snd_code_nxt;
        bit_pos_r   <= bit_pos_nxt;
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        frames_r    <= frames_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      level_r <= level;
      busy_r  <= busy;
      rej_r   <= rej;
      fin_r   <= fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = level_r;
  assign out_busy_res   = busy_r;
  assign out_rejected   = rej_r;
  assign out_finished   = fin_r;

  `DPCT_ASSERT_IMPL(a_fin_busy, out_valid_r && fin_r, busy_r && !rej_r,
                    "finishing transaction must report busy and not rejected")
  `DPCT_ASSERT(a_pos_range, bit_pos_r <= dpct_pkg::TRAILER,
               "bit position beyond trailer")
  `DPCT_ASSERT_IMPL(a_idle_frames, !active_r, frames_r == '0,
                    "frame count left over while idle")
  `DPCT_ASSERT_NEXT(a_fin_stops, take && fin, !active_r,
                    "sequencer still active after last frame")

endmodule

@@ rtl/doorbell_pulse_code_transmitter_top.sv @@
// Top level of the doorbell pulse code transmitter
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_ready   | in_req_type, in_channel, in_sound
//  out     | out_valid / out_ready | out_line_level, out_busy_res, out_rejected,
//          |                       | out_finished
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// One transaction per cycle while the result side does not stall: each one is held in the
// input register while the frame sequencer works it into the result register at the ports.
// The sequencer updates its state in the cycle a transaction passes it.
// Reset (rst_n low, synchronous) stops any transmission and loads the register defaults.
// A stalled result holds the result register; the input register still takes one more
// transaction, and in_ready drops only when both are full.
module doorbell_pulse_code_transmitter_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [dpct_pkg::CH_W-1:0]  in_channel,
  input  logic [dpct_pkg::SND_W-1:0] in_sound,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_line_level,
  output logic                       out_busy_res,
  output logic                       out_rejected,
  output logic                       out_finished,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [dpct_pkg::CFG_W-1:0] cfg_wdata
);

  dpct_pkg::item_t    in_item;
  dpct_pkg::in_slot_t slot;
  logic               take;

  assign in_item.req_type = in_req_type;
  assign in_item.channel  = in_channel;
  assign in_item.sound    = in_sound;

  dpct_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .slot     (slot)
  );

  dpct_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .slot           (slot),
    .take           (take),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected),
    .out_finished   (out_finished)
  );

endmodule

@@ tb/sv/tb_doorbell_pulse_code_transmitter_top.sv @@
// Testbench of the doorbell pulse code transmitter: line predictor, scoreboard and drivers
`timescale 1ns / 1ps

class pulse_scoreboard;
  typedef struct packed {
    bit level;
    bit busy;
    bit rej;
    bit fin;
  } line_res_t;

  // register copies
  bit [9:0] slot_len;
  bit [6:0] frames_cfg;
  bit [5:0] gap_len;

  // sequencer copy
  bit               tx_on;
  bit [3:0]         ch_code;
  bit [7:0]         snd_code;
  bit [3:0]         bit_pos;
  dpct_pkg::phase_t phase;
  bit [15:0]        ticks;
  bit [6:0]         frames_left;

  bit [3:0]  ch_tab [16];
  bit [7:0]  snd_tab [3];
  line_res_t line_q [$];
  int        errors;

  function new();
    ch_tab = '{4'hF, 4'h3, 4'hB, 4'h0, 4'h8, 4'h4, 4'hC, 4'h5,
               4'hD, 4'h1, 4'h9, 4'h2, 4'hA, 4'h6, 4'hE, 4'h7};
    snd_tab = '{8'hF7, 8'hFB, 8'hFD};
    slot_len = 10'd200;
    frames_cfg = 7'd100;
    gap_len = 6'd30;
    tx_on = 1'b0;
    ch_code = '0;
    snd_code = '0;
    bit_pos = '0;
    phase = dpct_pkg::PH_HIGH;
    ticks = '0;
    frames_left = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [9:0] data);
    case (idx)
      dpct_pkg::CFG_SLOT_TICKS:   slot_len = data;
      dpct_pkg::CFG_REPEAT_COUNT: frames_cfg = data[6:0];
      dpct_pkg::CFG_GAP_SLOTS:    gap_len = data[5:0];
      default: ;
    endcase
  endfunction

  function bit busy();
    return tx_on;
  endfunction

  function int pending();
    return line_q.size();
  endfunction

  function bit level_now();
    if (!tx_on)
      return 1'b0;
    if (bit_pos >= dpct_pkg::TRAILER)
      return phase == dpct_pkg::PH_HIGH;
    if (phase == dpct_pkg::PH_HIGH)
      return 1'b1;
    if (phase == dpct_pkg::PH_LOW)
      return 1'b0;
    if (bit_pos < 4)
      return ch_code[2'(4'd3 - bit_pos)];
    return snd_code[3'(4'd11 - bit_pos)];
  endfunction

  // Rewind to the first slot; true when the last frame has gone out
  function bit end_frame();
    bit_pos = '0;
    phase = dpct_pkg::PH_HIGH;
    ticks = '0;
    if (frames_left <= 1) begin
      frames_left = '0;
      tx_on = 1'b0;
      return 1'b1;
    end
    frames_left--;
    return 1'b0;
  endfunction

  function void note_input(bit req, bit [4:0] ch, bit [2:0] sn);
    line_res_t r;
    int slen;
    int t;
    r = '0;
    slen = (slot_len == 0) ? 1 : int'(slot_len);
    if (req) begin
      if (tx_on || ch < 1 || ch > 16 || sn < 1 || sn > 3) begin
        r.rej = 1'b1;
      end else begin
        ch_code = ch_tab[4'(ch - 5'd1)];
        snd_code = snd_tab[2'(sn - 3'd1)];
        bit_pos = '0;
        phase = dpct_pkg::PH_HIGH;
        ticks = '0;
        frames_left = (frames_cfg == 0) ? 7'd1 : frames_cfg;
        tx_on = 1'b1;
      end
      r.level = level_now();
      r.busy = tx_on;
    end else begin
      r.level = level_now();
      r.busy = tx_on;
      if (tx_on) begin
        t = int'(ticks) + 1;
        if (bit_pos >= dpct_pkg::TRAILER && phase != dpct_pkg::PH_HIGH) begin
          if (t >= int'(gap_len) * slen)
            r.fin = end_frame();
          else
            ticks = t[15:0];
        end else if (t >= slen) begin
          ticks = '0;
          if (bit_pos >= dpct_pkg::TRAILER) begin
            if (gap_len == 0)
              r.fin = end_frame();
            else
              phase = dpct_pkg::PH_LOW;
          end else if (phase == dpct_pkg::PH_BIT) begin
            phase = dpct_pkg::PH_HIGH;
            bit_pos++;
          end else begin
            phase = dpct_pkg::phase_t'(phase + 2'd1);
          end
        end else begin
          ticks = t[15:0];
        end
      end
    end
    line_q.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(bit level, bit busy_o, bit rej, bit fin);
    line_res_t e;
    if (line_q.size() == 0) begin
      report("result transaction with nothing expected");
    end else begin
      e = line_q.pop_front();
      if (level !== e.level)
        report($sformatf("line_level %0b, expected %0b", level, e.level));
      if (busy_o !== e.busy)
        report($sformatf("busy_res %0b, expected %0b", busy_o, e.busy));
      if (rej !== e.rej)
        report($sformatf("rejected %0b, expected %0b", rej, e.rej));
      if (fin !== e.fin)
        report($sformatf("finished %0b, expected %0b", fin, e.fin));
    end
  endtask
endclass

module tb_doorbell_pulse_code_transmitter_top;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         ITEM_TARGET = 1400;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_req_type = 1'b0;
  logic [dpct_pkg::CH_W-1:0]  in_channel = '0;
  logic [dpct_pkg::SND_W-1:0] in_sound = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_line_level;
  logic                       out_busy_res;
  logic                       out_rejected;
  logic                       out_finished;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  logic [dpct_pkg::CFG_W-1:0] cfg_wdata = '0;

  pulse_scoreboard sb = new();
  bit              calm = 1'b0;
  int              hold_req = 0;
  int              items_sent = 0;
  int              idle_cycles = 0;

  doorbell_pulse_code_transmitter_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_channel     (in_channel),
    .in_sound       (in_sound),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected),
    .out_finished   (out_finished),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [9:0] with_junk(logic [9:0] v, int w);
    logic [9:0] j;
    j = 10'($urandom);
    return (j & ~((10'd1 << w) - 10'd1)) | v;
  endfunction

  task automatic send(bit req, bit [4:0] ch, bit [2:0] sn);
    int g;
    g = (!calm && $urandom_range(0, 3) == 0) ? idle_span() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_channel <= ch;
    in_sound <= sn;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req, ch, sn);
    items_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    if (last)
      cfg_valid <= 1'b0;
  endtask

  task automatic tx_session(int idx, bit [9:0] s, bit [6:0] r, bit [5:0] g, int shrink_at,
                            bit squeeze);
    int n;
    bit [4:0] ch;
    bit [2:0] sn;
    drain();
    write_reg(dpct_pkg::CFG_SLOT_TICKS, s, 1'b0);
    write_reg(dpct_pkg::CFG_REPEAT_COUNT, with_junk(10'(r), 7), 1'b0);
    write_reg(dpct_pkg::CFG_GAP_SLOTS, with_junk(10'(g), 6), 1'b1);
    calm = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(0, 4))
      send(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
    ch = (idx < 16) ? 5'(idx + 1) : 5'($urandom_range(1, 16));
    sn = (idx < 16) ? 3'(idx % 3 + 1) : 3'($urandom_range(1, 3));
    if (squeeze) begin
      calm = 1'b1;
      hold_req = 60;
    end
    send(1'b1, ch, sn);
    n = 0;
    while (sb.busy()) begin
      if ($urandom_range(0, 24) == 0)
        send(1'b1, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
      else
        send(1'b0, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
      n++;
      // retune the registers mid-transmission
      if (n == shrink_at || (shrink_at == 0 && $urandom_range(0, 299) == 0)) begin
        drain();
        write_reg(dpct_pkg::CFG_SLOT_TICKS, 10'($urandom_range(0, 3)), 1'b0);
        write_reg(dpct_pkg::CFG_GAP_SLOTS, 10'($urandom_range(0, 5)), 1'b1);
      end
    end
    repeat ($urandom_range(0, 3))
      send(1'b0, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
  endtask

  // receiver: check each result transaction, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_line_level, out_busy_res, out_rejected, out_finished);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = idle_span() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int sess;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keep the first transmission short: two frames
    write_reg(dpct_pkg::CFG_REPEAT_COUNT, 10'd2, 1'b1);
    // idle ticks, bad selections, start at reset slot and gap, start while busy
    send(1'b0, 5'd0, 3'd0);
    send(1'b0, 5'd31, 3'd7);
    send(1'b1, 5'd0, 3'd1);
    send(1'b1, 5'd17, 3'd1);
    send(1'b1, 5'd31, 3'd7);
    send(1'b1, 5'd1, 3'd0);
    send(1'b1, 5'd16, 3'd4);
    send(1'b1, 5'd1, 3'd1);
    send(1'b1, 5'd2, 3'd2);
    repeat (4) send(1'b0, 5'd0, 3'd0);
    // shrink the slot below the elapsed count while busy
    drain();
    write_reg(dpct_pkg::CFG_SLOT_TICKS, 10'd1, 1'b0);
    write_reg(CFG_UNUSED, 10'h3FF, 1'b0);
    write_reg(dpct_pkg::CFG_REPEAT_COUNT, 10'd1, 1'b0);
    write_reg(dpct_pkg::CFG_GAP_SLOTS, 10'd0, 1'b1);
    while (sb.busy())
      send(1'b0, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
    send(1'b1, 5'd16, 3'd3);
    send(1'b1, 5'd16, 3'd3);

    tx_session(0, 10'd1023, 7'd1, 6'd1, 200, 1'b0);
    tx_session(1, 10'd1, 7'd5, 6'd0, 0, 1'b1);
    tx_session(2, 10'd0, 7'd0, 6'd63, 0, 1'b0);
    sess = 3;
    while (sess < 16 || items_sent < ITEM_TARGET) begin
      tx_session(sess, 10'($urandom_range(0, 2)), 7'($urandom_range(0, 1)),
                 6'($urandom_range(0, 5)), 0, 1'b0);
      sess++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/dpct_pkg.sv
rtl/dpct_in_stage.sv
rtl/dpct_core.sv
rtl/doorbell_pulse_code_transmitter_top.sv
tb/sv/tb_doorbell_pulse_code_transmitter_top.sv
